[design/qea_pkg.sv]
// Shared constants, types and helper functions for the quaternion to Euler angle block.
// Used by the channel interfaces, the square-root and CORDIC cells and the top level.
package qea_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int COMP_W           = 16;
    localparam int PROD_W           = 32;
    localparam int SUM_W            = 34;
    localparam int S_W              = 30;
    localparam int RAD_W            = 58;
    localparam int SQRT_STEPS       = 29;
    localparam int CORD_W           = 46;
    localparam int ACC_W            = 27;
    localparam int YAW_W            = 16;
    localparam int PITCH_W          = 15;

    localparam logic signed [SUM_W-1:0] UNIT_Q28     = SUM_W'(64'sd268435456);
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(32'sd9216000);
    localparam logic signed [ACC_W-1:0] HALF_LSB     = ACC_W'(32'sd512);
    localparam logic signed [ACC_W-1:0] YAW_LIMIT    = ACC_W'(32'sd18000);
    localparam logic signed [ACC_W-1:0] PITCH_LIMIT  = ACC_W'(32'sd9000);

    localparam logic signed [ACC_W-1:0] ATAN_TABLE [MAX_STEPS] = '{
        27'sd4608000, 27'sd2720261, 27'sd1437311, 27'sd729602,
        27'sd366217,  27'sd183287,  27'sd91666,   27'sd45836,
        27'sd22918,   27'sd11459,   27'sd5730,    27'sd2865,
        27'sd1432,    27'sd716,     27'sd358,     27'sd179,
        27'sd90,      27'sd45,      27'sd22,      27'sd11,
        27'sd6,       27'sd3,       27'sd1,       27'sd1
    };

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        logic                     zero;
    } cordic_vec_t;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } sqrt_vec_t;

    // Scales both operands by 256 and turns a left half-plane vector into the right one.
    function automatic cordic_vec_t cordic_prerotate(input logic signed [SUM_W-1:0] y_in,
                                                     input logic signed [SUM_W-1:0] x_in);
        cordic_vec_t              v;
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;
        xs     = CORD_W'(x_in) <<< 8;
        ys     = CORD_W'(y_in) <<< 8;
        v.zero = (x_in == '0) && (y_in == '0);
        v.x    = xs;
        v.y    = ys;
        v.acc  = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                v.x   = ys;
                v.y   = -xs;
                v.acc = QUARTER_TURN;
            end
            else
            begin
                v.x   = -ys;
                v.y   = xs;
                v.acc = -QUARTER_TURN;
            end
        end
        return v;
    endfunction

    // Rounds the accumulator to centidegrees.
    function automatic logic signed [ACC_W-1:0] cordic_round(input cordic_vec_t v);
        logic signed [ACC_W-1:0] r;
        r = (v.acc + HALF_LSB) >>> 10;
        if (v.zero)
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_angle(input logic signed [ACC_W-1:0] a,
                                                            input logic signed [ACC_W-1:0] lim);
        logic signed [ACC_W-1:0] r;
        r = a;
        if (a > lim)
        begin
            r = lim;
        end
        else if (a < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

[design/qea_in_if.sv]
// Input channel carrying one quaternion word with valid/ready handshake.
// Depends on qea_pkg for the component width.
interface qea_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [qea_pkg::COMP_W-1:0]  w_component;
    logic signed [qea_pkg::COMP_W-1:0]  x_component;
    logic signed [qea_pkg::COMP_W-1:0]  y_component;
    logic signed [qea_pkg::COMP_W-1:0]  z_component;

    modport source (output valid, w_component, x_component, y_component, z_component,
                    input ready);
    modport sink (input valid, w_component, x_component, y_component, z_component,
                  output ready);
endinterface

[design/qea_out_if.sv]
// Output channel carrying one word of Euler angles with valid/ready handshake.
// Depends on qea_pkg for the angle widths.
interface qea_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qea_pkg::YAW_W-1:0]    yaw_centideg;
    logic signed [qea_pkg::PITCH_W-1:0]  pitch_centideg;
    logic signed [qea_pkg::YAW_W-1:0]    roll_centideg;
    logic                                pitch_clamped;

    modport source (output valid, yaw_centideg, pitch_centideg, roll_centideg, pitch_clamped,
                    input ready);
    modport sink (input valid, yaw_centideg, pitch_centideg, roll_centideg, pitch_clamped,
                  output ready);
endinterface

[design/qea_sqrt_cell.sv]
// One bit of a pipelined restoring integer square root.
// Depends on qea_pkg for the remainder/root layout.
module qea_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               en,
    input  qea_pkg::sqrt_vec_t vec_in,
    output qea_pkg::sqrt_vec_t vec_out
);
    import qea_pkg::*;

    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

    sqrt_vec_t        vec_reg;
    sqrt_vec_t        vec_next;
    logic [RAD_W-1:0] trial;

    always_comb
    begin
        trial = vec_in.root + BIT;
        if (vec_in.rem >= trial)
        begin
            vec_next.rem  = vec_in.rem - trial;
            vec_next.root = (vec_in.root >> 1) + BIT;
        end
        else
        begin
            vec_next.rem  = vec_in.rem;
            vec_next.root = vec_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

[design/qea_cordic_cell.sv]
// One vectoring CORDIC iteration with a fixed shift and angle constant.
// Depends on qea_pkg for the vector layout and the arctangent table.
module qea_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  qea_pkg::cordic_vec_t vec_in,
    output qea_pkg::cordic_vec_t vec_out
);
    import qea_pkg::*;

    cordic_vec_t              vec_reg;
    cordic_vec_t              vec_next;
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;

    always_comb
    begin
        dx            = vec_in.y >>> STEP;
        dy            = vec_in.x >>> STEP;
        vec_next.zero = vec_in.zero;
        if (vec_in.y >= 0)
        begin
            vec_next.x   = vec_in.x + dx;
            vec_next.y   = vec_in.y - dy;
            vec_next.acc = vec_in.acc + ATAN_TABLE[STEP];
        end
        else
        begin
            vec_next.x   = vec_in.x - dx;
            vec_next.y   = vec_in.y + dy;
            vec_next.acc = vec_in.acc - ATAN_TABLE[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

[design/quaternion_to_euler_angles.sv]
// Top level of the quaternion to Euler angle converter.
// Depends on qea_pkg, qea_in_if, qea_out_if, qea_sqrt_cell and qea_cordic_cell.
//
// A word on quat holds a Q2.14 quaternion; a word on euler holds yaw, pitch and roll in
// hundredths of a degree plus a flag set when the arcsine argument was saturated.
// Both channels use valid/ready; a word moves when both are high at a clock edge.
// The block is one pipeline: products, sums, the square of the arcsine argument,
// a 29-cell square root that forms the arcsine cosine, a quarter-turn stage, and
// three rows of CORDIC_STEPS cells for yaw, roll and pitch, then the output register.
// One word is accepted every cycle while euler is not stalled.
// When euler holds a word that is not taken, the whole pipeline freezes and
// quat.ready drops; it rises again in the cycle the receiver takes the word.
// Reset clears all valid bits; no clearing of data is needed.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    qea_in_if.sink    quat,
    qea_out_if.source euler
);
    import qea_pkg::*;

    localparam int NV = 3 + SQRT_STEPS + 1 + CORDIC_STEPS;

    typedef struct packed {
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [S_W-1:0]   s;
        logic                    flag;
    } pay_t;

    logic                      en;
    logic [NV-1:0]             vld_reg;
    logic                      out_valid_reg;

    logic signed [PROD_W-1:0]  p_ww_reg, p_xx_reg, p_zz_reg, p_xy_reg, p_wz_reg;
    logic signed [PROD_W-1:0]  p_yz_reg, p_wx_reg, p_wy_reg, p_xz_reg;

    pay_t                      pay_next;
    pay_t                      pay_reg;
    logic signed [SUM_W-1:0]   s_raw;
    logic signed [2*S_W-1:0]   s_sq;
    logic [RAD_W-1:0]          rad_next;

    sqrt_vec_t                 sq_chain [SQRT_STEPS+1];
    pay_t                      pay_line [SQRT_STEPS+1];

    cordic_vec_t               yaw_chain   [CORDIC_STEPS+1];
    cordic_vec_t               roll_chain  [CORDIC_STEPS+1];
    cordic_vec_t               pitch_chain [CORDIC_STEPS+1];
    logic                      flag_line   [CORDIC_STEPS+1];

    logic signed [ACC_W-1:0]   yaw_next, roll_next, pitch_next;
    logic signed [YAW_W-1:0]   yaw_reg, roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic                      flag_reg;

    assign en         = !out_valid_reg || euler.ready;
    assign quat.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NV-2:0], quat.valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ww_reg <= quat.w_component * quat.w_component;
            p_xx_reg <= quat.x_component * quat.x_component;
            p_zz_reg <= quat.z_component * quat.z_component;
            p_xy_reg <= quat.x_component * quat.y_component;
            p_wz_reg <= quat.w_component * quat.z_component;
            p_yz_reg <= quat.y_component * quat.z_component;
            p_wx_reg <= quat.w_component * quat.x_component;
            p_wy_reg <= quat.w_component * quat.y_component;
            p_xz_reg <= quat.x_component * quat.z_component;
        end
    end

    always_comb
    begin
        pay_next.yaw_y  = (SUM_W'(p_xy_reg) - SUM_W'(p_wz_reg)) <<< 1;
        pay_next.yaw_x  = ((SUM_W'(p_ww_reg) + SUM_W'(p_xx_reg)) <<< 1) - UNIT_Q28;
        pay_next.roll_y = (SUM_W'(p_yz_reg) - SUM_W'(p_wx_reg)) <<< 1;
        pay_next.roll_x = ((SUM_W'(p_ww_reg) + SUM_W'(p_zz_reg)) <<< 1) - UNIT_Q28;
        s_raw           = (SUM_W'(p_wy_reg) + SUM_W'(p_xz_reg)) <<< 1;
        pay_next.flag   = (s_raw > UNIT_Q28) || (s_raw < -UNIT_Q28);
        if (s_raw > UNIT_Q28)
        begin
            pay_next.s = S_W'(UNIT_Q28);
        end
        else if (s_raw < -UNIT_Q28)
        begin
            pay_next.s = S_W'(-UNIT_Q28);
        end
        else
        begin
            pay_next.s = S_W'(s_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= pay_next;
        end
    end

    assign s_sq     = pay_reg.s * pay_reg.s;
    assign rad_next = (RAD_W'(1) << 56) - RAD_W'(s_sq);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_chain[0].rem  <= rad_next;
            sq_chain[0].root <= '0;
            pay_line[0]      <= pay_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        qea_sqrt_cell #(.STEP(k)) u_cell (
            .clk     (clk),
            .en      (en),
            .vec_in  (sq_chain[k]),
            .vec_out (sq_chain[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_line[k+1] <= pay_line[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_chain[0]   <= cordic_prerotate(pay_line[SQRT_STEPS].yaw_y,
                                               pay_line[SQRT_STEPS].yaw_x);
            roll_chain[0]  <= cordic_prerotate(pay_line[SQRT_STEPS].roll_y,
                                               pay_line[SQRT_STEPS].roll_x);
            pitch_chain[0] <= cordic_prerotate(SUM_W'(pay_line[SQRT_STEPS].s),
                                               SUM_W'(sq_chain[SQRT_STEPS].root[S_W-2:0]));
            flag_line[0]   <= pay_line[SQRT_STEPS].flag;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        qea_cordic_cell #(.STEP(i)) u_yaw (
            .clk     (clk),
            .en      (en),
            .vec_in  (yaw_chain[i]),
            .vec_out (yaw_chain[i+1])
        );

        qea_cordic_cell #(.STEP(i)) u_roll (
            .clk     (clk),
            .en      (en),
            .vec_in  (roll_chain[i]),
            .vec_out (roll_chain[i+1])
        );

        qea_cordic_cell #(.STEP(i)) u_pitch (
            .clk     (clk),
            .en      (en),
            .vec_in  (pitch_chain[i]),
            .vec_out (pitch_chain[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flag_line[i+1] <= flag_line[i];
            end
        end
    end

    always_comb
    begin
        yaw_next   = clamp_angle(cordic_round(yaw_chain[CORDIC_STEPS]), YAW_LIMIT);
        roll_next  = clamp_angle(cordic_round(roll_chain[CORDIC_STEPS]), YAW_LIMIT);
        pitch_next = clamp_angle(-cordic_round(pitch_chain[CORDIC_STEPS]), PITCH_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg   <= yaw_next[YAW_W-1:0];
            roll_reg  <= roll_next[YAW_W-1:0];
            pitch_reg <= pitch_next[PITCH_W-1:0];
            flag_reg  <= flag_line[CORDIC_STEPS];
        end
    end

    assign euler.valid          = out_valid_reg;
    assign euler.yaw_centideg   = yaw_reg;
    assign euler.roll_centideg  = roll_reg;
    assign euler.pitch_centideg = pitch_reg;
    assign euler.pitch_clamped  = flag_reg;

    a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (euler.valid && euler.pitch_clamped) |->
            (euler.pitch_centideg == PITCH_W'(9000) || euler.pitch_centideg == -PITCH_W'(9000)))
        else $error("clamped pitch is not at a pole");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.yaw_centideg <= 16'sd18000 && euler.yaw_centideg >= -16'sd18000
                         && euler.roll_centideg <= 16'sd18000
                         && euler.roll_centideg >= -16'sd18000))
        else $error("yaw or roll out of range");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (euler.valid && !euler.ready) |=> ($stable(vld_reg) && euler.valid))
        else $error("pipeline moved while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (quat.valid && quat.ready) |=> vld_reg[0])
        else $error("accepted word not tracked");

endmodule

[dv/quaternion_to_euler_angles_chk.sv]
// Checker for the quaternion to Euler angle converter: watches both channels, computes
// the expected angles for each accepted quaternion and compares each result word.
// Depends on qea_pkg, qea_in_if and qea_out_if.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_chk #(
    parameter int CORDIC_STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    qea_in_if         quat,
    qea_out_if        euler,
    output int        fail_count,
    output int        pending_count,
    output int        words_checked,
    output int        clamped_seen
);

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic               clamped;
    } angles_t;

    localparam longint ONE_Q28 = 64'sd1 << 28;

    localparam longint ARC_STEP [24] = '{
        4608000, 2720261, 1437311, 729602, 366217, 183287, 91666, 45836,
        22918, 11459, 5730, 2865, 1432, 716, 358, 179,
        90, 45, 22, 11, 6, 3, 1, 1
    };

    angles_t expected_angles[$];

    function automatic longint vector_angle(input longint yv, input longint xv);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        if (xv == 0 && yv == 0)
        begin
            return 0;
        end
        xv  = xv * 256;
        yv  = yv * 256;
        acc = 0;
        if (xv < 0)
        begin
            t = xv;
            if (yv >= 0)
            begin
                xv  = yv;
                yv  = -t;
                acc = 9000 * 1024;
            end
            else
            begin
                xv  = -yv;
                yv  = t;
                acc = -9000 * 1024;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv  = xv + dx;
                yv  = yv - dy;
                acc = acc + ARC_STEP[i];
            end
            else
            begin
                xv  = xv - dx;
                yv  = yv + dy;
                acc = acc - ARC_STEP[i];
            end
        end
        return (acc + 512) >>> 10;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return longint'(root);
    endfunction

    function automatic longint limit(input longint v, input longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic angles_t euler_of(input longint w, input longint x,
                                         input longint y, input longint z);
        angles_t r;
        longint  s;
        longint  c;
        s         = 2 * (w * y + x * z);
        r.clamped = (s > ONE_Q28) || (s < -ONE_Q28);
        s         = limit(s, ONE_Q28);
        c         = floor_sqrt((64'd1 << 56) - longint'(s * s));
        r.yaw     = 16'(limit(vector_angle(2 * (x * y - w * z),
                                           2 * (w * w + x * x) - ONE_Q28), 18000));
        r.roll    = 16'(limit(vector_angle(2 * (y * z - w * x),
                                           2 * (w * w + z * z) - ONE_Q28), 18000));
        r.pitch   = 15'(limit(-vector_angle(s, c), 9000));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        angles_t e;
        if (!rst_n)
        begin
            fail_count    <= 0;
            words_checked <= 0;
            clamped_seen  <= 0;
            pending_count <= 0;
            expected_angles.delete();
        end
        else
        begin
            if (quat.valid && quat.ready)
            begin
                expected_angles.push_back(euler_of(quat.w_component, quat.x_component,
                                                   quat.y_component, quat.z_component));
            end
            if (euler.valid && euler.ready)
            begin
                words_checked <= words_checked + 1;
                if (euler.pitch_clamped)
                begin
                    clamped_seen <= clamped_seen + 1;
                end
                if (expected_angles.size() == 0)
                begin
                    report_mismatch("unexpected word", 1, 0);
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (euler.yaw_centideg !== e.yaw)
                    begin
                        report_mismatch("yaw", euler.yaw_centideg, e.yaw);
                    end
                    if (euler.pitch_centideg !== e.pitch)
                    begin
                        report_mismatch("pitch", euler.pitch_centideg, e.pitch);
                    end
                    if (euler.roll_centideg !== e.roll)
                    begin
                        report_mismatch("roll", euler.roll_centideg, e.roll);
                    end
                    if (euler.pitch_clamped !== e.clamped)
                    begin
                        report_mismatch("clamp flag", euler.pitch_clamped, e.clamped);
                    end
                end
            end
            pending_count <= expected_angles.size();
        end
    end

endmodule

[dv/quaternion_to_euler_angles_tb.sv]
// Top of the quaternion to Euler angle testbench: clock, reset, quaternion stimulus,
// result back-pressure and the verdict. Depends on the block, its interfaces and the checker.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   words_checked;
    int   clamped_seen;
    int   idle_cycles;
    int   sent_count;
    bit   stall_enable;

    qea_in_if  quat();
    qea_out_if euler();

    quaternion_to_euler_angles DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat),
        .euler (euler)
    );

    quaternion_to_euler_angles_chk checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .quat          (quat),
        .euler         (euler),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .words_checked (words_checked),
        .clamped_seen  (clamped_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        quat.valid       = 1'b0;
        quat.w_component = '0;
        quat.x_component = '0;
        quat.y_component = '0;
        quat.z_component = '0;
        euler.ready      = 1'b0;
        rst_n            = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: draws a stall before each word, with stall-free stretches.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = stall_enable ? $urandom_range(0, 18) : 0;
            if (wait_cycles != 0)
            begin
                euler.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            euler.ready <= 1'b1;
            @(posedge clk);
            while (!euler.valid)
            begin
                @(posedge clk);
            end
        end
    end

    task automatic send_quaternion(input logic [15:0] w, input logic [15:0] x,
                                   input logic [15:0] y, input logic [15:0] z,
                                   input int gap);
        if (gap != 0)
        begin
            quat.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quat.valid       <= 1'b1;
        quat.w_component <= w;
        quat.x_component <= x;
        quat.y_component <= y;
        quat.z_component <= z;
        @(posedge clk);
        while (!quat.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    function automatic logic [15:0] rand_component(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 32768)) - 16384);
            2: return 16'($signed($urandom_range(0, 24000)) - 12000);
            default: return 16'($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
        endcase
    endfunction

    initial
    begin
        logic [15:0] w, x, y, z;
        int          mode;
        int          gap;
        stall_enable = 1'b1;
        sent_count   = 0;
        @(posedge rst_n);
        @(posedge clk);
        send_quaternion(16'sd16384, 0, 0, 0, 0);
        send_quaternion(0, 16'sd16384, 0, 0, 0);
        send_quaternion(0, 0, 16'sd16384, 0, 0);
        send_quaternion(0, 0, 0, 16'sd16384, 0);
        send_quaternion(0, 0, 0, 0, 0);
        send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
        send_quaternion(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
        send_quaternion(16'sd11585, 0, 16'sd11585, 0, 0);
        send_quaternion(16'sd11585, 0, -16'sd11585, 0, 2);
        send_quaternion(16'sd11586, 0, 16'sd11586, 0, 0);
        send_quaternion(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
        send_quaternion(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 0);
        send_quaternion(16'sd11585, 16'sd11585, 0, 0, 0);
        send_quaternion(16'sd11585, -16'sd11585, 0, 0, 3);
        send_quaternion(16'sd11585, 0, 0, 16'sd11585, 0);
        send_quaternion(0, 16'sd11585, 0, -16'sd11585, 0);
        send_quaternion(1, 0, 0, 0, 0);
        send_quaternion(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 0);
        send_quaternion(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);

        quat.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end

        for (int n = 0; n < 500; n++)
        begin
            if (n % 100 == 60)
            begin
                stall_enable = ~stall_enable;
            end
            mode = $urandom_range(0, 9);
            mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
            w = rand_component(mode);
            x = rand_component(mode);
            y = rand_component(mode);
            z = rand_component(mode);
            gap = ((n / 50) % 3 == 1) ? 0 : $urandom_range(0, 18);
            send_quaternion(w, x, y, z, gap);
        end
        quat.valid <= 1'b0;
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((quat.valid && quat.ready) || (euler.valid && euler.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding.", pending_count);
                $display("TEST FAILED");
                $finish;
            end
            if (sent_count == 520 && pending_count == 0)
            begin
                repeat (DRAIN_CYCLES) @(posedge clk);
                $display("Checked %0d angle words from %0d quaternions, %0d with pitch clamped.",
                         words_checked, sent_count, clamped_seen);
                if (fail_count == 0 && pending_count == 0)
                begin
                    $display("TEST PASSED");
                end
                else
                begin
                    $display("TEST FAILED");
                end
                $finish;
            end
        end
    end

endmodule

[files.f]
design/qea_pkg.sv
design/qea_in_if.sv
design/qea_out_if.sv
design/qea_sqrt_cell.sv
design/qea_cordic_cell.sv
design/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_chk.sv
dv/quaternion_to_euler_angles_tb.sv
